@@ sv/mts_pkg.sv @@
// Shared constants for the melody tone sequencer.
`default_nettype none

package mts_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    // Note time in microsecond ticks before division by the length divisor
    localparam int WAIT_W = 20;
    localparam logic [WAIT_W-1:0] NOTE_TIME_US = 20'd900000;

    localparam int NOTE_W  = 16;
    localparam int DUR_W   = 8;
    localparam int LEVEL_W = 13;
    localparam int POS_W   = 8;
    localparam int SONG_W  = 9;

    // Input item kinds
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Play phases
    localparam logic [1:0] PH_NOTE    = 2'd0;
    localparam logic [1:0] PH_GAP     = 2'd1;
    localparam logic [1:0] PH_ADVANCE = 2'd2;

    // Register word select (paddr[2])
    localparam logic REG_SONG_PAIRS = 1'b0;
    localparam logic REG_REST_CODE  = 1'b1;

endpackage

`default_nettype wire

@@ sv/mts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/melody_tone_sequencer.sv @@
// Melody tone sequencer: melody store, note/gap/advance sequencer and serial divider.
`default_nettype none

// A stream of items drives a buzzer melody held in an on-chip store of (tone period,
// length divisor) pairs. Load items write pairs, tick items stand for one microsecond
// each, restart items rewind the song and send a silence setting. A tick that fires a
// note or gap event reads the store, then runs a shared restoring divider one quotient
// bit per cycle over 20 bits (900000 / divisor, the gap waiting half the quotient): the
// steps are accept, fetch, one divider step per quotient bit, finish and result. The
// index step (index + 1 modulo song length) runs the same divider without fetch or
// result. The result register decouples the output side; a new result waits only
// while the previous one has not been taken. The store has no reset and needs no
// clearing pass: entries must be loaded before they are played.
module melody_tone_sequencer #(
    parameter int TABLE_DEPTH = mts_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // load_index[7:0], load_note[23:8], load_duration[31:24]
    input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,  // tone_wrap[15:0], tone_level[28:16], note_position[36:29]
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DW   = (IDXW + 1 > 9) ? IDXW + 1 : 9;
    localparam int WW   = mts_pkg::WAIT_W;
    localparam int CNTW = $clog2(WW + 1);
    localparam int RAMW = mts_pkg::NOTE_W + mts_pkg::DUR_W;
    localparam logic [DW-1:0] DEPTH_D = DW'(TABLE_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_DONE  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    // ---------------- registers ----------------
    logic [mts_pkg::SONG_W-1:0] r_song_pairs;
    logic [mts_pkg::NOTE_W-1:0] r_rest_code;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_song_pairs <= mts_pkg::SONG_W'(1);
            r_rest_code  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                mts_pkg::REG_SONG_PAIRS: r_song_pairs <= pwdata[mts_pkg::SONG_W-1:0];
                mts_pkg::REG_REST_CODE:  r_rest_code  <= pwdata[mts_pkg::NOTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == mts_pkg::REG_SONG_PAIRS) ?
                    {{(32 - mts_pkg::SONG_W){1'b0}}, r_song_pairs} :
                    {{(32 - mts_pkg::NOTE_W){1'b0}}, r_rest_code};

    // ---------------- input unpack ----------------
    logic [1:0]                 in_op;
    logic [7:0]                 in_index;
    logic [mts_pkg::NOTE_W-1:0] in_note;
    logic [mts_pkg::DUR_W-1:0]  in_dur;
    logic                       in_acc;
    logic [DW-1:0]              in_index_ext;
    logic                       load_we;

    assign in_op        = s_axis_tuser;
    assign in_index     = s_axis_tdata[7:0];
    assign in_note      = s_axis_tdata[23:8];
    assign in_dur       = s_axis_tdata[31:24];
    assign in_acc       = s_axis_tvalid & s_axis_tready;
    assign in_index_ext = DW'(in_index);
    assign load_we      = in_acc && (in_op == mts_pkg::OP_LOAD) && (in_index_ext < DEPTH_D);

    // ---------------- sequencer state ----------------
    logic [2:0]                  r_state, n_state;
    logic [1:0]                  r_phase, n_phase;
    logic [IDXW-1:0]             r_idx, n_idx;
    logic [WW-1:0]               r_wait, n_wait;
    logic [mts_pkg::NOTE_W-1:0]  r_note, n_note;
    logic [WW-1:0]               r_dvd, n_dvd;    // dividend, becomes quotient
    logic [DW-1:0]               r_dvs, n_dvs;
    logic [DW-1:0]               r_rem, n_rem;
    logic [CNTW-1:0]             r_cnt, n_cnt;
    logic [mts_pkg::NOTE_W-1:0]  r_res_wrap, n_res_wrap;
    logic [mts_pkg::LEVEL_W-1:0] r_res_level, n_res_level;

    logic                        r_out_valid;
    logic [mts_pkg::NOTE_W-1:0]  r_out_wrap;
    logic [mts_pkg::LEVEL_W-1:0] r_out_level;
    logic [mts_pkg::POS_W-1:0]   r_out_pos;

    logic [RAMW-1:0]             ram_rdata;
    logic [mts_pkg::DUR_W-1:0]   rd_dur;
    logic [DW-1:0]               song_ext;
    logic [DW-1:0]               eff_pairs;
    logic [DW-1:0]               idx_ext;
    logic [WW-1:0]               wait_dec;
    logic [DW:0]                 trial;
    logic [DW:0]                 diff;
    logic                        ge;
    logic                        emit_fire;

    mts_ram #(
        .WIDTH (RAMW),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (in_index_ext[IDXW-1:0]),
        .i_wdata ({in_dur, in_note}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_dur    = ram_rdata[RAMW-1:mts_pkg::NOTE_W];
    assign song_ext  = DW'(r_song_pairs);
    assign eff_pairs = (song_ext == '0)     ? DW'(1) :
                       (song_ext > DEPTH_D) ? DEPTH_D : song_ext;
    assign idx_ext   = DW'(r_idx);
    assign wait_dec  = (r_wait != '0) ? r_wait - WW'(1) : r_wait;

    // restoring divider step
    assign trial = {r_rem, r_dvd[WW-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    assign s_axis_tready = (r_state == ST_IDLE);
    assign emit_fire     = (r_state == ST_EMIT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_wait      = r_wait;
        n_note      = r_note;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_res_wrap  = r_res_wrap;
        n_res_level = r_res_level;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_op)
                        mts_pkg::OP_TICK: begin
                            n_wait = wait_dec;
                            if (wait_dec == '0) begin
                                if (r_phase == mts_pkg::PH_ADVANCE) begin
                                    // index step: (index + 1) mod song length
                                    n_dvd   = WW'(idx_ext + DW'(1));
                                    n_dvs   = eff_pairs;
                                    n_rem   = '0;
                                    n_cnt   = CNTW'(WW);
                                    n_state = ST_DIV;
                                end else begin
                                    n_state = ST_FETCH;
                                end
                            end
                        end
                        mts_pkg::OP_RESTART: begin
                            n_idx       = '0;
                            n_wait      = '0;
                            n_phase     = mts_pkg::PH_NOTE;
                            n_res_wrap  = '0;
                            n_res_level = '0;
                            n_state     = ST_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: begin
                n_note  = ram_rdata[mts_pkg::NOTE_W-1:0];
                n_dvs   = (rd_dur == '0) ? DW'(1) : DW'(rd_dur);
                n_dvd   = mts_pkg::NOTE_TIME_US;
                n_rem   = '0;
                n_cnt   = CNTW'(WW);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
                n_dvd = {r_dvd[WW-2:0], ge};
                n_cnt = r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                case (r_phase)
                    mts_pkg::PH_ADVANCE: begin
                        n_idx   = r_rem[IDXW-1:0];
                        n_phase = mts_pkg::PH_NOTE;
                        n_state = ST_IDLE;
                    end
                    mts_pkg::PH_GAP: begin
                        n_wait      = r_dvd >> 1;
                        n_phase     = mts_pkg::PH_ADVANCE;
                        n_res_wrap  = '0;
                        n_res_level = '0;
                        n_state     = ST_EMIT;
                    end
                    default: begin
                        n_wait  = r_dvd;
                        n_phase = mts_pkg::PH_GAP;
                        if (r_note == r_rest_code) begin
                            n_res_wrap  = '0;
                            n_res_level = '0;
                        end else begin
                            n_res_wrap  = r_note;
                            n_res_level = r_note[mts_pkg::NOTE_W-1:3];
                        end
                        n_state = ST_EMIT;
                    end
                endcase
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= mts_pkg::PH_NOTE;
            r_idx   <= '0;
            r_wait  <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_wait  <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        r_note      <= n_note;
        r_dvd       <= n_dvd;
        r_dvs       <= n_dvs;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_res_wrap  <= n_res_wrap;
        r_res_level <= n_res_level;
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_wrap  <= r_res_wrap;
            r_out_level <= r_res_level;
            r_out_pos   <= idx_ext[mts_pkg::POS_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_pos, r_out_level, r_out_wrap};

    // ---------------- assertions ----------------
    a_idx_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idx_ext < DEPTH_D)
        else $error("pair index beyond store depth");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_dvs != '0 && r_rem < r_dvs))
        else $error("divider remainder not below divisor");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_op == mts_pkg::OP_RESTART) |=>
        (r_idx == '0 && r_wait == '0 && r_state == ST_EMIT && r_phase == mts_pkg::PH_NOTE))
        else $error("restart did not rewind the song");

    a_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_wrap == '0) |-> (r_out_level == '0))
        else $error("silent setting with nonzero level");

endmodule

`default_nettype wire
